// ----- rtl/wbdc_pkg.sv -----
// Shared types, constants and data-lane helpers for the write-back data cache.
`timescale 1ns / 1ps
package wbdc_pkg;

	localparam int AddrW      = 16;
	localparam int DataW      = 32;
	localparam int PolicyW    = 6;
	localparam int PolicyIdxW = 3;
	localparam int LfsrW      = 32;
	localparam int LfsrTapHigh = 31;
	localparam int LfsrTapMid  = 21;
	localparam int LatW       = 4;
	localparam int ApbAddrW   = 4;

	localparam int DefWays      = 4;
	localparam int DefSets      = 64;
	localparam int DefLineWords = 4;
	localparam int DefMemWords  = 16384;

	localparam int QueueDepth = 2;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	localparam logic [1:0] RegReadLatency  = 2'd0;
	localparam logic [1:0] RegWriteLatency = 2'd1;
	localparam logic [1:0] RegReplaceMode  = 2'd2;

	localparam logic [LatW-1:0] ResetReadLatency  = 4'd2;
	localparam logic [LatW-1:0] ResetWriteLatency = 4'd2;

	localparam logic [1:0] ModeWayZero = 2'd0;
	localparam logic [1:0] ModeFifo    = 2'd1;
	localparam logic [1:0] ModeLru     = 2'd2;
	localparam logic [1:0] ModeRandom  = 2'd3;

	localparam logic [1:0] SizeByte = 2'd0;
	localparam logic [1:0] SizeHalf = 2'd1;

	typedef struct packed {
		logic             cache_enable;
		logic             write_request;
		logic [1:0]       access_size;
		logic             sign_extend;
		logic [AddrW-1:0] byte_address;
		logic [DataW-1:0] store_value;
	} request_t;

	typedef struct packed {
		logic [DataW-1:0] load_value;
		logic             access_done;
	} result_t;

	typedef struct packed {
		logic [LatW-1:0] read_latency;
		logic [LatW-1:0] write_latency;
		logic [1:0]      replacement_mode;
	} cfg_t;

	typedef enum logic [2:0] {
		PH_IDLE          = 3'd0,
		PH_STORE_CONTROL = 3'd1,
		PH_STORE_DATA    = 3'd2,
		PH_FIRST_WB      = 3'd3,
		PH_WB            = 3'd4,
		PH_FETCH         = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		M_CLEAR,
		M_IDLE,
		M_LOOK,
		M_DATA,
		M_HOLD_LINE,
		M_HOLD_MEM
	} micro_t;

	function automatic logic [DataW-1:0] load_format(input logic [DataW-1:0] w,
			input logic [1:0] lane, input logic [1:0] size, input logic sgn);
		logic [7:0]  b;
		logic [15:0] h;
		logic [DataW-1:0] r;
		b = w[{lane, 3'b000} +: 8];
		h = lane[1] ? w[31:16] : w[15:0];
		unique case (size)
			SizeByte: r = {{24{sgn & b[7]}}, b};
			SizeHalf: r = {{16{sgn & h[15]}}, h};
			default:  r = w;
		endcase
		return r;
	endfunction

	function automatic logic [DataW-1:0] store_merge(input logic [DataW-1:0] w,
			input logic [1:0] lane, input logic [1:0] size, input logic [DataW-1:0] v);
		logic [DataW-1:0] r;
		r = w;
		unique case (size)
			SizeByte: r[{lane, 3'b000} +: 8] = v[7:0];
			SizeHalf: r[{lane[1], 4'b0000} +: 16] = v[15:0];
			default:  r = v;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/wbdc_front.sv -----
// Request queue in front of the cache engine.
`timescale 1ns / 1ps
module wbdc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  wbdc_pkg::request_t  request,
	output logic                item_valid,
	output wbdc_pkg::request_t  item,
	input  logic                item_pop
);

	wbdc_pkg::request_t             q_mem_q [wbdc_pkg::QueueDepth];
	logic [wbdc_pkg::QPtrW-1:0]     wr_q, rd_q;
	logic [wbdc_pkg::QCntW-1:0]     count_q;
	logic                           push;

	assign busy       = (count_q == wbdc_pkg::QCntW'(wbdc_pkg::QueueDepth));
	assign push       = start && !busy;
	assign item_valid = (count_q != '0);
	assign item       = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_q] <= request;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (item_pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + wbdc_pkg::QCntW'(push) - wbdc_pkg::QCntW'(item_pop);
		end
	end

endmodule

// ----- rtl/wbdc_back.sv -----
// Cache engine: tag lookup, hit/miss handling, write-back and refill sequencing.
`timescale 1ns / 1ps
module wbdc_back #(
	parameter int WAYS       = wbdc_pkg::DefWays,
	parameter int SETS       = wbdc_pkg::DefSets,
	parameter int LINE_WORDS = wbdc_pkg::DefLineWords,
	parameter int MEM_WORDS  = wbdc_pkg::DefMemWords
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wbdc_pkg::cfg_t     cfg,
	input  logic               item_valid,
	input  wbdc_pkg::request_t item,
	output logic               item_pop,
	output logic               result_valid,
	output wbdc_pkg::result_t  result
);

	localparam int WordW  = wbdc_pkg::AddrW - 2;
	localparam int WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int OffW   = $clog2(LINE_WORDS);
	localparam int SetW   = $clog2(SETS);
	localparam int TagW   = WordW - OffW - SetW;
	localparam int LineN  = SETS * LINE_WORDS * WAYS;
	localparam int LineAW = $clog2(LineN);
	localparam int MemAW  = $clog2(MEM_WORDS);

	typedef struct packed {
		logic [WAYS-1:0][TagW-1:0]        tag;
		logic [WAYS-1:0]                  valid;
		logic [WAYS-1:0]                  dirty;
		logic [wbdc_pkg::PolicyW-1:0]     policy;
	} ctrl_t;

	function automatic int lru_bit(input int a, input int b);
		return ((b * (b - 1)) >> 1) + a;
	endfunction

	function automatic logic [WayW-1:0] ways_mod(input logic [31:0] v);
		logic [5:0] s;
		logic [3:0] t;
		logic [WayW-1:0] r;
		s = '0;
		t = '0;
		r = '0;
		if (WAYS == 1) begin
			r = '0;
		end else if ((WAYS & (WAYS - 1)) == 0) begin
			r = v[WayW-1:0];
		end else begin
			// three ways: 4 = 1 mod 3, so sum base-4 digits
			for (int i = 0; i < 16; i++) s = s + 6'(v[2*i +: 2]);
			t = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
			if (t >= 4'd6) t = t - 4'd6;
			else if (t >= 4'd3) t = t - 4'd3;
			r = t[WayW-1:0];
		end
		return r;
	endfunction

	function automatic logic [wbdc_pkg::PolicyW-1:0] promote(
			input logic [wbdc_pkg::PolicyW-1:0] p, input logic [WayW-1:0] w);
		logic [wbdc_pkg::PolicyW-1:0] r;
		r = p;
		for (int j = 0; j < WAYS; j++) begin
			if (WayW'(j) == w) begin
				for (int k = 0; k < WAYS; k++) begin
					if (k < j) r[wbdc_pkg::PolicyIdxW'(lru_bit(k, j))] = 1'b1;
					else if (k > j) r[wbdc_pkg::PolicyIdxW'(lru_bit(j, k))] = 1'b0;
				end
			end
		end
		return r;
	endfunction

	function automatic logic [WayW-1:0] pick_way(input ctrl_t c, input logic [1:0] mode,
			input logic [wbdc_pkg::LfsrW-1:0] rnd);
		logic [WayW-1:0] w;
		logic older;
		w = '0;
		older = 1'b0;
		unique case (mode)
			wbdc_pkg::ModeFifo:   w = ways_mod(32'(c.policy));
			wbdc_pkg::ModeRandom: w = ways_mod(rnd);
			wbdc_pkg::ModeLru: begin
				for (int i = 1; i < WAYS; i++) begin
					older = 1'b1;
					for (int a = 0; a < i; a++)
						if (c.policy[wbdc_pkg::PolicyIdxW'(lru_bit(a, i))]) older = 1'b0;
					if (older) w = WayW'(i);
				end
			end
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [LineAW-1:0] line_addr(input logic [SetW-1:0] s,
			input logic [OffW-1:0] o, input logic [WayW-1:0] w);
		return LineAW'(32'({s, o}) * WAYS + 32'(w));
	endfunction

	function automatic logic [MemAW-1:0] mem_addr(input logic [TagW-1:0] t,
			input logic [SetW-1:0] s, input logic [OffW-1:0] o);
		return MemAW'(32'({t, s, o}));
	endfunction

	function automatic logic [OffW-1:0] addr_off(input logic [wbdc_pkg::AddrW-1:0] a);
		return a[2 +: OffW];
	endfunction

	function automatic logic [SetW-1:0] addr_set(input logic [wbdc_pkg::AddrW-1:0] a);
		return a[2 + OffW +: SetW];
	endfunction

	function automatic logic [TagW-1:0] addr_tag(input logic [wbdc_pkg::AddrW-1:0] a);
		return a[wbdc_pkg::AddrW-1 -: TagW];
	endfunction

	// memories
	ctrl_t                       ctrl_mem [SETS];
	logic [wbdc_pkg::DataW-1:0]  line_mem [LineN];
	logic [wbdc_pkg::DataW-1:0]  back_mem [MEM_WORDS];
	ctrl_t                       ctrl_rd_q;
	logic [wbdc_pkg::DataW-1:0]  line_rd_q, mem_rd_q;
	logic [SETS-1:0]             rowvalid_q;
	logic                        rv_q;

	logic                        ctrl_we;
	logic [SetW-1:0]             ctrl_raddr;
	logic                        line_we;
	logic [LineAW-1:0]           line_waddr, line_raddr;
	logic [wbdc_pkg::DataW-1:0]  line_wdata;
	logic                        mem_we;
	logic [MemAW-1:0]            mem_waddr, mem_raddr;
	logic [wbdc_pkg::DataW-1:0]  mem_wdata;

	// architectural state
	wbdc_pkg::micro_t            micro_q, micro_d;
	wbdc_pkg::phase_t            phase_q, phase_d;
	logic [SetW-1:0]             set_q, set_d;
	logic [WayW-1:0]             way_q, way_d;
	logic [OffW-1:0]             cursor_q, cursor_d;
	logic [wbdc_pkg::LatW-1:0]   wait_q, wait_d;
	logic [wbdc_pkg::DataW-1:0]  held_q, held_d;
	logic [wbdc_pkg::AddrW-1:0]  paddr_q, paddr_d;
	ctrl_t                       copy_q, copy_d;
	logic [wbdc_pkg::LfsrW-1:0]  lfsr_q, lfsr_d;
	logic [MemAW-1:0]            clr_q, clr_d;
	wbdc_pkg::request_t          cur_q, cur_d;
	logic                        hit_q, hit_d;

	logic                        emit, emit_done;
	logic [wbdc_pkg::DataW-1:0]  emit_val;
	logic                        result_valid_q;
	wbdc_pkg::result_t           result_q;

	ctrl_t                       ctrl_eff;
	logic                        hit;
	logic [WayW-1:0]             hw, pw;
	logic [OffW-1:0]             ncur;
	logic [wbdc_pkg::DataW-1:0]  word;
	logic                        fb;

	always_ff @(posedge clk) begin
		if (ctrl_we) ctrl_mem[set_q] <= copy_q;
		ctrl_rd_q <= ctrl_mem[ctrl_raddr];
		rv_q      <= rowvalid_q[ctrl_raddr];
	end

	always_ff @(posedge clk) begin
		if (line_we) line_mem[line_waddr] <= line_wdata;
		line_rd_q <= line_mem[line_raddr];
	end

	always_ff @(posedge clk) begin
		if (mem_we) back_mem[mem_waddr] <= mem_wdata;
		mem_rd_q <= back_mem[mem_raddr];
	end

	assign fb = lfsr_q[wbdc_pkg::LfsrTapHigh] ^ lfsr_q[wbdc_pkg::LfsrTapMid] ^
		lfsr_q[1] ^ lfsr_q[0];

	always_comb begin
		micro_d   = micro_q;
		phase_d   = phase_q;
		set_d     = set_q;
		way_d     = way_q;
		cursor_d  = cursor_q;
		wait_d    = wait_q;
		held_d    = held_q;
		paddr_d   = paddr_q;
		copy_d    = copy_q;
		lfsr_d    = lfsr_q;
		clr_d     = clr_q;
		cur_d     = cur_q;
		hit_d     = hit_q;
		item_pop  = 1'b0;
		ctrl_we   = 1'b0;
		ctrl_raddr = addr_set(item.byte_address);
		line_we   = 1'b0;
		line_waddr = '0;
		line_wdata = held_q;
		line_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = held_q;
		mem_raddr = '0;
		emit      = 1'b0;
		emit_done = 1'b0;
		emit_val  = '0;
		ncur      = cursor_q + 1'b1;
		word      = '0;
		ctrl_eff  = rv_q ? ctrl_rd_q : '0;
		hit       = 1'b0;
		hw        = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (ctrl_eff.valid[i] && ctrl_eff.tag[i] == addr_tag(cur_q.byte_address)) begin
				hit = 1'b1;
				hw  = WayW'(i);
			end
		end
		pw = pick_way(ctrl_eff, cfg.replacement_mode, lfsr_q);

		unique case (micro_q)
			wbdc_pkg::M_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == MemAW'(MEM_WORDS - 1)) micro_d = wbdc_pkg::M_IDLE;
			end
			wbdc_pkg::M_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					cur_d    = item;
					unique case (phase_q)
						wbdc_pkg::PH_IDLE: begin
							if (item.cache_enable) micro_d = wbdc_pkg::M_LOOK;
							else emit = 1'b1;
						end
						wbdc_pkg::PH_STORE_CONTROL: begin
							ctrl_we = 1'b1;
							phase_d = wbdc_pkg::PH_IDLE;
							emit    = 1'b1;
						end
						wbdc_pkg::PH_STORE_DATA: begin
							ctrl_we    = 1'b1;
							line_we    = 1'b1;
							line_waddr = line_addr(set_q, addr_off(paddr_q), way_q);
							phase_d    = wbdc_pkg::PH_IDLE;
							emit       = 1'b1;
						end
						wbdc_pkg::PH_FIRST_WB: begin
							cursor_d   = '0;
							wait_d     = '0;
							line_raddr = line_addr(set_q, '0, way_q);
							phase_d    = wbdc_pkg::PH_WB;
							micro_d    = wbdc_pkg::M_HOLD_LINE;
							emit       = 1'b1;
						end
						wbdc_pkg::PH_WB: begin
							emit = 1'b1;
							if (wait_q == cfg.write_latency) begin
								mem_we    = 1'b1;
								mem_waddr = mem_addr(copy_q.tag[way_q], set_q, cursor_q);
								cursor_d  = ncur;
								wait_d    = '0;
								if (ncur != '0) begin
									line_raddr = line_addr(set_q, ncur, way_q);
									micro_d    = wbdc_pkg::M_HOLD_LINE;
								end else begin
									phase_d = wbdc_pkg::PH_STORE_CONTROL;
									copy_d.dirty[way_q] = 1'b0;
								end
							end else begin
								wait_d = wait_q + 1'b1;
							end
						end
						wbdc_pkg::PH_FETCH: begin
							emit = 1'b1;
							if (wait_q == cfg.read_latency) begin
								line_we    = 1'b1;
								line_waddr = line_addr(set_q, cursor_q, way_q);
								cursor_d   = ncur;
								wait_d     = '0;
								if (ncur != addr_off(paddr_q)) begin
									mem_raddr = mem_addr(copy_q.tag[way_q], set_q, ncur);
									micro_d   = wbdc_pkg::M_HOLD_MEM;
								end else begin
									phase_d = wbdc_pkg::PH_STORE_CONTROL;
									copy_d.valid[way_q] = 1'b1;
									if (cfg.replacement_mode == wbdc_pkg::ModeLru)
										copy_d.policy = promote(copy_q.policy, way_q);
								end
							end else begin
								wait_d = wait_q + 1'b1;
							end
						end
						default: begin
							phase_d = wbdc_pkg::PH_IDLE;
							emit    = 1'b1;
						end
					endcase
				end
			end
			wbdc_pkg::M_LOOK: begin
				copy_d   = ctrl_eff;
				set_d    = addr_set(cur_q.byte_address);
				cursor_d = addr_off(cur_q.byte_address);
				hit_d    = hit;
				way_d    = hit ? hw : pw;
				if (hit) begin
					line_raddr = line_addr(addr_set(cur_q.byte_address),
						addr_off(cur_q.byte_address), hw);
					micro_d = wbdc_pkg::M_DATA;
				end else if (ctrl_eff.dirty[pw] && ctrl_eff.valid[pw]) begin
					// dirty victim: write the line back, requester retries later
					phase_d  = wbdc_pkg::PH_FIRST_WB;
					cursor_d = '0;
					paddr_d  = wbdc_pkg::AddrW'({ctrl_eff.tag[pw],
						addr_set(cur_q.byte_address), OffW'(0), 2'b00});
					emit     = 1'b1;
					micro_d  = wbdc_pkg::M_IDLE;
				end else begin
					mem_raddr = MemAW'(32'(cur_q.byte_address[wbdc_pkg::AddrW-1:2]));
					micro_d   = wbdc_pkg::M_DATA;
				end
			end
			wbdc_pkg::M_DATA: begin
				micro_d   = wbdc_pkg::M_IDLE;
				emit      = 1'b1;
				emit_done = 1'b1;
				if (hit_q) begin
					word = line_rd_q;
					if (cur_q.write_request) begin
						held_d  = wbdc_pkg::store_merge(word, cur_q.byte_address[1:0],
							cur_q.access_size, cur_q.store_value);
						paddr_d = cur_q.byte_address;
						copy_d.dirty[way_q] = 1'b1;
						phase_d = wbdc_pkg::PH_STORE_DATA;
					end else begin
						emit_val = wbdc_pkg::load_format(word, cur_q.byte_address[1:0],
							cur_q.access_size, cur_q.sign_extend);
						phase_d  = wbdc_pkg::PH_STORE_CONTROL;
					end
					if (cfg.replacement_mode == wbdc_pkg::ModeLru)
						copy_d.policy = promote(copy_q.policy, way_q);
				end else begin
					word = mem_rd_q;
					copy_d.tag[way_q]   = addr_tag(cur_q.byte_address);
					copy_d.valid[way_q] = 1'b0;
					paddr_d = cur_q.byte_address;
					phase_d = wbdc_pkg::PH_FETCH;
					wait_d  = wbdc_pkg::LatW'(1);
					if (cur_q.write_request) begin
						held_d = wbdc_pkg::store_merge(word, cur_q.byte_address[1:0],
							cur_q.access_size, cur_q.store_value);
						copy_d.dirty[way_q] = 1'b1;
					end else begin
						held_d = word;
						copy_d.dirty[way_q] = 1'b0;
						emit_val = wbdc_pkg::load_format(word, cur_q.byte_address[1:0],
							cur_q.access_size, cur_q.sign_extend);
					end
					if (WAYS >= 2) begin
						case (cfg.replacement_mode)
							wbdc_pkg::ModeFifo: begin
								if (ways_mod(32'(copy_q.policy)) == WayW'(WAYS - 1))
									copy_d.policy = '0;
								else
									copy_d.policy = wbdc_pkg::PolicyW'(
										ways_mod(32'(copy_q.policy))) + 1'b1;
							end
							wbdc_pkg::ModeLru:
								copy_d.policy = promote(copy_q.policy, way_q);
							wbdc_pkg::ModeRandom:
								lfsr_d = {lfsr_q[wbdc_pkg::LfsrW-2:0], fb};
							default: ;
						endcase
					end
				end
			end
			wbdc_pkg::M_HOLD_LINE: begin
				held_d  = line_rd_q;
				micro_d = wbdc_pkg::M_IDLE;
			end
			wbdc_pkg::M_HOLD_MEM: begin
				held_d  = mem_rd_q;
				micro_d = wbdc_pkg::M_IDLE;
			end
			default: micro_d = wbdc_pkg::M_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			micro_q        <= wbdc_pkg::M_CLEAR;
			phase_q        <= wbdc_pkg::PH_IDLE;
			set_q          <= '0;
			way_q          <= '0;
			cursor_q       <= '0;
			wait_q         <= '0;
			held_q         <= '0;
			paddr_q        <= '0;
			copy_q         <= '0;
			lfsr_q         <= wbdc_pkg::LfsrW'(1);
			clr_q          <= '0;
			rowvalid_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			micro_q        <= micro_d;
			phase_q        <= phase_d;
			set_q          <= set_d;
			way_q          <= way_d;
			cursor_q       <= cursor_d;
			wait_q         <= wait_d;
			held_q         <= held_d;
			paddr_q        <= paddr_d;
			copy_q         <= copy_d;
			lfsr_q         <= lfsr_d;
			clr_q          <= clr_d;
			if (ctrl_we) rowvalid_q[set_q] <= 1'b1;
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		hit_q    <= hit_d;
		result_q <= '{load_value: emit_val, access_done: emit_done};
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_done_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.access_done |-> $past(micro_q == wbdc_pkg::M_DATA))
		else $error("completed transaction not from data step");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		micro_q == wbdc_pkg::M_CLEAR |-> !item_pop)
		else $error("transaction taken during memory clear");
	a_store_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wbdc_pkg::PH_STORE_DATA |-> copy_q.dirty[way_q])
		else $error("store data pending on clean way");

endmodule

// ----- rtl/write_back_data_cache.sv -----
// Top level: APB register file, request queue and cache engine.
`timescale 1ns / 1ps
// Each accepted transaction yields one result strobe; the receiver cannot stall.
// Results are registered. Idle ticks, control writes and write-back/refill word steps are
// answered from the idle step; a lookup passes the look step and, unless it finds a dirty
// victim, the data step. The engine takes a new transaction only in its idle step, so a
// lookup, or a word step that loads the next word through a hold step, holds the queue.
// Reset: asynchronous; backing memory (MEM_WORDS words, 16384 by default) is cleared
// before the first transaction; a 2-entry queue still accepts during the clear.
module write_back_data_cache #(
	parameter int WAYS       = wbdc_pkg::DefWays,
	parameter int SETS       = wbdc_pkg::DefSets,
	parameter int LINE_WORDS = wbdc_pkg::DefLineWords,
	parameter int MEM_WORDS  = wbdc_pkg::DefMemWords
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wbdc_pkg::ApbAddrW-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  wbdc_pkg::request_t            request,
	output logic                          result_valid,
	output wbdc_pkg::result_t             result
);

	wbdc_pkg::cfg_t     cfg_q;
	logic               cfg_wr;
	logic [1:0]         reg_idx;
	logic               item_valid;
	logic               item_pop;
	wbdc_pkg::request_t item;

	// config registers: the user must write them only while the engine is quiet; not enforced here
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_latency     <= wbdc_pkg::ResetReadLatency;
			cfg_q.write_latency    <= wbdc_pkg::ResetWriteLatency;
			cfg_q.replacement_mode <= wbdc_pkg::ModeLru;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				wbdc_pkg::RegReadLatency:  cfg_q.read_latency  <= pwdata[wbdc_pkg::LatW-1:0];
				wbdc_pkg::RegWriteLatency: cfg_q.write_latency <= pwdata[wbdc_pkg::LatW-1:0];
				wbdc_pkg::RegReplaceMode:  cfg_q.replacement_mode <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			wbdc_pkg::RegReadLatency:  prdata = 32'(cfg_q.read_latency);
			wbdc_pkg::RegWriteLatency: prdata = 32'(cfg_q.write_latency);
			wbdc_pkg::RegReplaceMode:  prdata = 32'(cfg_q.replacement_mode);
			default:                   prdata = '0;
		endcase
	end

	// front: takes transactions while the engine works on earlier ones
	wbdc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// back: one cache tick per queued transaction, result strobed for one cycle
	wbdc_back #(
		.WAYS       (WAYS),
		.SETS       (SETS),
		.LINE_WORDS (LINE_WORDS),
		.MEM_WORDS  (MEM_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ----- tb/sv/tb_write_back_data_cache.sv -----
// Testbench for the write-back data cache: random and directed accesses checked against a predictor.
`timescale 1ns / 1ps
module tb_write_back_data_cache;

	// tags, valid/dirty bits and pairwise age bits of one set
	typedef struct packed {
		bit [3:0][5:0] tag;
		bit [3:0]      valid;
		bit [3:0]      dirty;
		bit [5:0]      age;
	} set_state_t;

	// Tick-level model of the cache plus the queue of results it predicts.
	class cache_scoreboard;
		bit [31:0]  line_mem [64][4][4];   // [set][word][way]
		bit [31:0]  main_mem [16384];
		set_state_t set_mem [64];
		set_state_t open_copy;
		wbdc_pkg::phase_t phase;
		bit [5:0]   open_set;
		bit [1:0]   way_sel, cursor;
		bit [3:0]   wait_cnt, rd_lat, wr_lat;
		bit [1:0]   mode;
		bit [31:0]  held, lfsr;
		bit [15:0]  pend_addr;
		wbdc_pkg::result_t pending_results [$];
		int         mismatches, results_seen, completed, noted;

		function new();
			foreach (line_mem[s, w, k]) line_mem[s][w][k] = '0;
			foreach (main_mem[i]) main_mem[i] = '0;
			foreach (set_mem[i]) set_mem[i] = '0;
			open_copy = '0;
			phase = wbdc_pkg::PH_IDLE;
			open_set = '0; way_sel = '0; cursor = '0; wait_cnt = '0;
			held = '0; pend_addr = '0; lfsr = 32'd1;
			rd_lat = wbdc_pkg::ResetReadLatency; wr_lat = wbdc_pkg::ResetWriteLatency;
			mode = wbdc_pkg::ModeLru;
		endfunction

		function void set_reg(bit [1:0] idx, bit [31:0] v);
			case (idx)
				wbdc_pkg::RegReadLatency:  rd_lat = v[3:0];
				wbdc_pkg::RegWriteLatency: wr_lat = v[3:0];
				wbdc_pkg::RegReplaceMode:  mode = v[1:0];
				default: ;
			endcase
		endfunction

		static function int age_bit(int a, int b);
			return b * (b - 1) / 2 + a;
		endfunction

		function bit [1:0] victim_way();
			bit older;
			if (mode == wbdc_pkg::ModeFifo) return open_copy.age[1:0];
			if (mode == wbdc_pkg::ModeRandom) return lfsr[1:0];
			if (mode == wbdc_pkg::ModeLru) begin
				for (int w = 3; w >= 1; w--) begin
					older = 1'b1;
					for (int a = 0; a < w; a++)
						if (open_copy.age[age_bit(a, w)]) older = 1'b0;
					if (older) return w[1:0];
				end
			end
			return 2'd0;
		endfunction

		function void make_newest(int way);
			if (mode != wbdc_pkg::ModeLru) return;
			for (int k = 0; k < 4; k++) begin
				if (k < way) open_copy.age[age_bit(k, way)] = 1'b1;
				else if (k > way) open_copy.age[age_bit(way, k)] = 1'b0;
			end
		endfunction

		function void on_fill(int way);
			if (mode == wbdc_pkg::ModeFifo) open_copy.age = {4'd0, open_copy.age[1:0] + 2'd1};
			else if (mode == wbdc_pkg::ModeLru) make_newest(way);
			else if (mode == wbdc_pkg::ModeRandom)
				lfsr = {lfsr[30:0], lfsr[wbdc_pkg::LfsrTapHigh] ^ lfsr[wbdc_pkg::LfsrTapMid] ^
					lfsr[1] ^ lfsr[0]};
		endfunction

		static function bit [31:0] shape_load(bit [31:0] w, bit [15:0] a, bit [1:0] sz, bit sx);
			bit [7:0]  b;
			bit [15:0] h;
			b = 8'(w >> (a[1:0] * 8));
			h = 16'(w >> (a[1] * 16));
			if (sz == wbdc_pkg::SizeByte) return {{24{sx & b[7]}}, b};
			if (sz == wbdc_pkg::SizeHalf) return {{16{sx & h[15]}}, h};
			return w;
		endfunction

		static function bit [31:0] merge_store(bit [31:0] w, bit [15:0] a, bit [1:0] sz,
				bit [31:0] v);
			bit [31:0] m;
			if (sz == wbdc_pkg::SizeByte) begin
				m = 32'hFF << (a[1:0] * 8);
				return (w & ~m) | ((v & 32'hFF) << (a[1:0] * 8));
			end
			if (sz == wbdc_pkg::SizeHalf) begin
				m = 32'hFFFF << (a[1] * 16);
				return (w & ~m) | ((v & 32'hFFFF) << (a[1] * 16));
			end
			return v;
		endfunction

		// advance the model by one tick; the predicted result is queued and returned
		function wbdc_pkg::result_t note_request(wbdc_pkg::request_t r);
			wbdc_pkg::result_t res;
			bit hit;
			bit [1:0] hw, off;
			res = '0;
			noted++;
			case (phase)
				wbdc_pkg::PH_IDLE: if (r.cache_enable) begin
					open_set = r.byte_address[9:4];
					off = r.byte_address[3:2];
					cursor = off;
					open_copy = set_mem[open_set];
					hit = 1'b0; hw = '0;
					for (int i = 0; i < 4; i++)
						if (open_copy.tag[i] == r.byte_address[15:10] && open_copy.valid[i]) begin
							hit = 1'b1; hw = i[1:0];
						end
					if (hit) begin
						way_sel = hw;
						if (r.write_request) begin
							held = merge_store(line_mem[open_set][off][hw], r.byte_address,
								r.access_size, r.store_value);
							pend_addr = r.byte_address;
							open_copy.dirty[hw] = 1'b1;
							phase = wbdc_pkg::PH_STORE_DATA;
						end else begin
							res.load_value = shape_load(line_mem[open_set][off][hw], r.byte_address,
								r.access_size, r.sign_extend);
							phase = wbdc_pkg::PH_STORE_CONTROL;
						end
						make_newest(hw);
						res.access_done = 1'b1;
					end else begin
						way_sel = victim_way();
						if (open_copy.dirty[way_sel] && open_copy.valid[way_sel]) begin
							phase = wbdc_pkg::PH_FIRST_WB;
							cursor = '0;
						end else begin
							open_copy.tag[way_sel] = r.byte_address[15:10];
							pend_addr = r.byte_address;
							phase = wbdc_pkg::PH_FETCH;
							open_copy.valid[way_sel] = 1'b0;
							held = main_mem[r.byte_address[15:2]];
							wait_cnt = 4'd1;
							if (r.write_request) begin
								held = merge_store(held, r.byte_address, r.access_size, r.store_value);
								open_copy.dirty[way_sel] = 1'b1;
							end else begin
								open_copy.dirty[way_sel] = 1'b0;
								res.load_value = shape_load(held, r.byte_address, r.access_size,
									r.sign_extend);
							end
							res.access_done = 1'b1;
							on_fill(way_sel);
						end
					end
				end
				wbdc_pkg::PH_STORE_CONTROL: begin
					set_mem[open_set] = open_copy;
					phase = wbdc_pkg::PH_IDLE;
				end
				wbdc_pkg::PH_STORE_DATA: begin
					set_mem[open_set] = open_copy;
					line_mem[open_set][pend_addr[3:2]][way_sel] = held;
					phase = wbdc_pkg::PH_IDLE;
				end
				wbdc_pkg::PH_FIRST_WB: begin
					cursor = '0;
					wait_cnt = '0;
					held = line_mem[open_set][0][way_sel];
					phase = wbdc_pkg::PH_WB;
				end
				wbdc_pkg::PH_WB: begin
					if (wait_cnt == wr_lat) begin
						main_mem[{open_copy.tag[way_sel], open_set, cursor}] = held;
						cursor = cursor + 2'd1;
						if (cursor != 2'd0) held = line_mem[open_set][cursor][way_sel];
						else begin
							phase = wbdc_pkg::PH_STORE_CONTROL;
							open_copy.dirty[way_sel] = 1'b0;
						end
						wait_cnt = '0;
					end else wait_cnt = wait_cnt + 4'd1;
				end
				wbdc_pkg::PH_FETCH: begin
					if (wait_cnt == rd_lat) begin
						line_mem[open_set][cursor][way_sel] = held;
						cursor = cursor + 2'd1;
						if (cursor != pend_addr[3:2])
							held = main_mem[{open_copy.tag[way_sel], open_set, cursor}];
						else begin
							phase = wbdc_pkg::PH_STORE_CONTROL;
							open_copy.valid[way_sel] = 1'b1;
							make_newest(way_sel);
						end
						wait_cnt = '0;
					end else wait_cnt = wait_cnt + 4'd1;
				end
				default: phase = wbdc_pkg::PH_IDLE;
			endcase
			if (res.access_done) completed++;
			pending_results.push_back(res);
			return res;
		endfunction

		function void check_result(wbdc_pkg::result_t got);
			wbdc_pkg::result_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result load_value=%h access_done=%b", $time,
					got.load_value, got.access_done);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.load_value !== want.load_value) begin
				$display("%0t: load_value expected %h actual %h", $time, want.load_value,
					got.load_value);
				mismatches++;
			end
			if (got.access_done !== want.access_done) begin
				$display("%0t: access_done expected %b actual %b", $time, want.access_done,
					got.access_done);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [wbdc_pkg::ApbAddrW-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               start = 1'b0;
	logic               busy;
	wbdc_pkg::request_t request = '0;
	logic               result_valid;
	wbdc_pkg::result_t  result;

	cache_scoreboard sb;
	int sender_idle_pct;   // chance in percent of a gap before each tick
	int accesses;

	write_back_data_cache i_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.start, .busy, .request, .result_valid, .result
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// results cannot be stalled: every strobe is a transaction
	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_result(result);
	end

	// APB write: setup cycle, then access cycle; pready is tied high
	task automatic reg_write(logic [1:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// one tick transaction; start is left high, the next tick decides whether to drop it
	task automatic send_tick(wbdc_pkg::request_t r, output wbdc_pkg::result_t predicted);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		predicted = sb.note_request(r);
	endtask

	// present a request until the cache completes it (dirty misses need a retry)
	task automatic do_access(wbdc_pkg::request_t r);
		wbdc_pkg::result_t p;
		wbdc_pkg::request_t noise;
		int tries;
		tries = 0;
		do begin
			send_tick(r, p);
			tries++;
			// now and then an idle tick or a stray request lands in the middle
			if (!p.access_done && $urandom_range(9) == 0) begin
				noise = wbdc_pkg::request_t'({$urandom, $urandom});
				noise.cache_enable = 1'($urandom_range(1));
				send_tick(noise, p);
				if (p.access_done) break;
			end
		end while (!p.access_done && tries < 400);
		accesses++;
	endtask

	function automatic wbdc_pkg::request_t rand_access();
		wbdc_pkg::request_t r;
		r.cache_enable = 1'b1;
		r.write_request = 1'($urandom_range(1));
		r.access_size = 2'($urandom_range(3));
		r.sign_extend = 1'($urandom_range(1));
		r.store_value = $urandom;
		// few tags over few sets so lines collide and dirty victims get evicted
		r.byte_address = 16'($urandom);
		if ($urandom_range(9) != 0) begin
			r.byte_address[15:10] = 6'($urandom_range(7));
			r.byte_address[9:4] = 6'($urandom_range(3));
		end
		return r;
	endfunction

	function automatic wbdc_pkg::request_t mk(bit wr, bit [1:0] sz, bit sx, bit [15:0] a,
			bit [31:0] v);
		wbdc_pkg::request_t r;
		r.cache_enable = 1'b1;
		r.write_request = wr;
		r.access_size = sz;
		r.sign_extend = sx;
		r.byte_address = a;
		r.store_value = v;
		return r;
	endfunction

	task automatic drain();
		start <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		wbdc_pkg::request_t r;
		wbdc_pkg::result_t p;
		int ticks_end;
		logic [3:0] rl [6] = '{4'd2, 4'd1, 4'd15, 4'd3, 4'd0, 4'd1};
		logic [3:0] wl [6] = '{4'd2, 4'd1, 4'd15, 4'd1, 4'd5, 4'd15};
		logic [1:0] md [6] = '{wbdc_pkg::ModeLru, wbdc_pkg::ModeWayZero, wbdc_pkg::ModeFifo,
			wbdc_pkg::ModeRandom, wbdc_pkg::ModeLru, wbdc_pkg::ModeRandom};
		sb = new();
		sender_idle_pct = 16;
		accesses = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: lanes, sign extension, size three, misalignment, address extremes
		do_access(mk(1'b1, 2'd2, 1'b0, 16'h0000, 32'h80FF_7F01));
		for (int i = 0; i < 4; i++) do_access(mk(1'b0, wbdc_pkg::SizeByte, i[0], 16'(i), 32'h0));
		do_access(mk(1'b0, wbdc_pkg::SizeHalf, 1'b1, 16'h0003, 32'h0));
		do_access(mk(1'b0, wbdc_pkg::SizeHalf, 1'b0, 16'h0001, 32'h0));
		do_access(mk(1'b0, 2'd3, 1'b1, 16'h0002, 32'h0));
		do_access(mk(1'b1, wbdc_pkg::SizeByte, 1'b0, 16'hFFFF, 32'hFFFF_FFFF));
		do_access(mk(1'b1, wbdc_pkg::SizeHalf, 1'b0, 16'hFFFD, 32'h1234_8765));
		do_access(mk(1'b0, 2'd2, 1'b0, 16'hFFFF, 32'h0));
		do_access(mk(1'b1, 2'd3, 1'b0, 16'h0007, 32'hDEAD_BEEF));
		// five tags in one set: dirty victim goes back to memory, then reread
		for (int t = 1; t < 6; t++) do_access(mk(1'b1, 2'd2, 1'b0, 16'(t << 10), 32'(t)));
		do_access(mk(1'b0, 2'd2, 1'b0, 16'h0000, 32'h0));
		do_access(mk(1'b0, 2'd2, 1'b0, 16'h0400, 32'h0));
		r = '0;
		send_tick(r, p);

		// each setting gets about 200 ticks
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) sender_idle_pct = 85;
			if (ph == 4) sender_idle_pct = 0;
			if (ph != 0) begin
				drain();
				reg_write(wbdc_pkg::RegReadLatency, {28'd0, rl[ph]});
				reg_write(wbdc_pkg::RegWriteLatency, {28'd0, wl[ph]});
				reg_write(wbdc_pkg::RegReplaceMode, {30'd0, md[ph]});
			end
			ticks_end = sb.noted + 200;
			while (sb.noted < ticks_end) begin
				if ($urandom_range(19) == 0) begin
					r = wbdc_pkg::request_t'({$urandom, $urandom});
					r.cache_enable = 1'b0;
					send_tick(r, p);
				end
				do_access(rand_access());
			end
		end
		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d ticks in %0d accesses (%0d completed, %0d results) over six",
			sb.noted, accesses, sb.completed, sb.results_seen);
		$display("latency/replacement settings with sender gaps of 16, 85 and 0 percent");
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#60ms;
		$display("timeout with %0d results outstanding", sb.pending_results.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
